[sv/clx_pkg.sv]
package clx_pkg;

  localparam int POS_W      = 16;
  localparam int TEXT_LIMIT = 32;
  localparam int TEXT_MAX   = TEXT_LIMIT - 2;
  localparam int LEN_W      = $clog2(TEXT_MAX + 1);
  localparam int KW_N       = 16;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [LEN_W-1:0] len_t;

  localparam logic [5:0] K_END  = 6'd0;
  localparam logic [5:0] K_SEMI = 6'd1;
  localparam logic [5:0] K_INT  = 6'd2;
  localparam logic [5:0] K_SYM  = 6'd3;
  localparam logic [5:0] K_STR  = 6'd4;
  localparam logic [5:0] K_AMP  = 6'd31;
  localparam logic [5:0] K_AND  = 6'd32;
  localparam logic [5:0] K_ASG  = 6'd33;
  localparam logic [5:0] K_EQ   = 6'd34;
  localparam logic [5:0] K_NOT  = 6'd35;
  localparam logic [5:0] K_NE   = 6'd36;
  localparam logic [5:0] K_LT   = 6'd37;
  localparam logic [5:0] K_SHL  = 6'd38;
  localparam logic [5:0] K_LE   = 6'd39;
  localparam logic [5:0] K_GT   = 6'd40;
  localparam logic [5:0] K_SHR  = 6'd41;
  localparam logic [5:0] K_GE   = 6'd42;

  localparam logic [1:0] E_NONE    = 2'd0;
  localparam logic [1:0] E_UNKNOWN = 2'd1;
  localparam logic [1:0] E_LONG    = 2'd2;
  localparam logic [1:0] E_UNTERM  = 2'd3;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;

  typedef enum logic [3:0] {
    M_IDLE, M_INT, M_SYM, M_STR, M_AMP, M_EQ, M_BANG, M_LT, M_GT
  } mode_e;

  typedef enum logic {BK_IDLE, BK_TEXT} bk_e;

  localparam logic [63:0] KW_WORD [KW_N] = '{
    64'("if"), 64'("else"), 64'("while"), 64'("do"), 64'("for"), 64'("continue"),
    64'("int"), 64'("short"), 64'("char"), 64'("signed"), 64'("unsigned"),
    64'("void"), 64'("switch"), 64'("case"), 64'("break"), 64'("goto")
  };
  localparam logic [3:0] KW_LEN [KW_N] = '{
    4'd2, 4'd4, 4'd5, 4'd2, 4'd3, 4'd8, 4'd3, 4'd5,
    4'd4, 4'd6, 4'd8, 4'd4, 4'd6, 4'd4, 4'd5, 4'd4
  };
  localparam logic [5:0] KW_KIND [KW_N] = '{
    6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd11,
    6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19
  };

  typedef struct packed {
    logic [5:0] kind;
    pos_t       line;
    pos_t       column;
    logic [7:0] tbyte;
    logic       has;
    logic       text;
    len_t       len;
    logic       bank;
    logic [1:0] err;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic [LEN_W:0]   addr;
    logic [7:0]       data;
  } wr_t;

  function automatic pos_t sat_add(pos_t v, logic [2:0] d);
    logic [POS_W:0] s;
    s = {1'b0, v} + (POS_W + 1)'(d);
    return s[POS_W] ? '1 : s[POS_W-1:0];
  endfunction

  function automatic logic [7:0] kw_char(int k, len_t i);
    int sh;
    sh = 8 * (int'(KW_LEN[k]) - 1 - int'(i));
    if (int'(i) < int'(KW_LEN[k])) begin
      return 8'(KW_WORD[k] >> sh);
    end
    return 8'h00;
  endfunction

  function automatic logic [KW_N-1:0] cand_upd(logic [KW_N-1:0] c, len_t i, logic [7:0] ch);
    logic [KW_N-1:0] r;
    for (int k = 0; k < KW_N; k++) begin
      r[k] = c[k] && (kw_char(k, i) == ch);
    end
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [7:0] lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic [5:0] single_kind(logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      ",":     k = 6'd20;
      "(":     k = 6'd21;
      ")":     k = 6'd22;
      "[":     k = 6'd23;
      "]":     k = 6'd24;
      "{":     k = 6'd25;
      "}":     k = 6'd26;
      "+":     k = 6'd27;
      "-":     k = 6'd28;
      "/":     k = 6'd29;
      "*":     k = 6'd30;
      "%":     k = 6'd43;
      ":":     k = 6'd44;
      ";":     k = K_SEMI;
      default: k = K_END;
    endcase
    return k;
  endfunction

  function automatic cmd_t mk_cmd(logic [5:0] kind, pos_t ln, pos_t col, logic [7:0] b,
                                  logic has, logic text, len_t len, logic bank,
                                  logic [1:0] err);
    cmd_t r;
    r.kind = kind; r.line = ln; r.column = col; r.tbyte = b; r.has = has;
    r.text = text; r.len = len; r.bank = bank; r.err = err; r.last = 1'b0;
    return r;
  endfunction

endpackage

[sv/clx_front.sv]
module clx_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    acc_i,
  input  logic [7:0]              byte_i,
  input  logic                    eof_i,
  output logic                    halted_o,
  output logic [1:0]              push_n_o,
  output clx_pkg::cmd_t [2:0]     cmds_o,
  output clx_pkg::wr_t            wr_o
);

  clx_pkg::mode_e              mode_q, mode_d;
  logic [5:0]                  pend_q, pend_d;
  clx_pkg::len_t               len_q, len_d;
  clx_pkg::pos_t               sl_q, sl_d, sc_q, sc_d, line_q, line_d, col_q, col_d;
  logic                        prev_q, prev_d, halt_q, halt_d, bank_q, bank_d;
  logic [clx_pkg::KW_N-1:0]    cand_q, cand_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= clx_pkg::M_IDLE;
      pend_q <= clx_pkg::K_END;
      len_q  <= '0;
      sl_q   <= clx_pkg::pos_t'(1);
      sc_q   <= '0;
      line_q <= clx_pkg::pos_t'(1);
      col_q  <= '0;
      prev_q <= 1'b0;
      halt_q <= 1'b0;
      bank_q <= 1'b0;
      cand_q <= '0;
    end else begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      len_q  <= len_d;
      sl_q   <= sl_d;
      sc_q   <= sc_d;
      line_q <= line_d;
      col_q  <= col_d;
      prev_q <= prev_d;
      halt_q <= halt_d;
      bank_q <= bank_d;
      cand_q <= cand_d;
    end
  end

  assign halted_o = halt_q;

  always_comb begin
    logic [7:0]          c, cch;
    clx_pkg::pos_t       ln, cl;
    logic                done, e1, e1t, capp, f3, hit, txt;
    logic [5:0]          e1k, hk, sk;
    logic [1:0]          n;
    clx_pkg::cmd_t [2:0] cv;
    mode_d = mode_q; pend_d = pend_q; len_d = len_q; sl_d = sl_q; sc_d = sc_q;
    line_d = line_q; col_d = col_q; prev_d = prev_q; halt_d = halt_q;
    bank_d = bank_q; cand_d = cand_q;
    n = '0; cv = '0; wr_o = '0;
    done = 1'b0; e1 = 1'b0; e1t = 1'b0; e1k = clx_pkg::K_END;
    capp = 1'b0; cch = 8'h00; f3 = 1'b0; txt = 1'b0;
    sk = clx_pkg::K_END;
    c = eof_i ? clx_pkg::CH_NUL : byte_i;

    hit = 1'b0; hk = clx_pkg::K_SYM;
    for (int k = 0; k < clx_pkg::KW_N; k++) begin
      if (!hit && cand_q[k] && clx_pkg::len_t'(clx_pkg::KW_LEN[k]) == len_q) begin
        hit = 1'b1;
        hk  = clx_pkg::KW_KIND[k];
      end
    end

    cl = clx_pkg::sat_add(col_q, 3'd1);
    ln = line_q;
    if (c == clx_pkg::CH_NUL || c == clx_pkg::CH_LF) begin
      ln = clx_pkg::sat_add(line_q, 3'd1);
      cl = '0;
    end else if (c == clx_pkg::CH_TAB) begin
      cl = clx_pkg::sat_add(cl, 3'd3);
    end else if (c == clx_pkg::CH_CR) begin
      cl = '0;
    end

    if (acc_i && !halt_q) begin
      line_d = ln;
      col_d  = cl;

      unique case (mode_q)
        clx_pkg::M_INT: begin
          if (clx_pkg::is_digit(c)) begin
            capp = 1'b1; cch = c; done = 1'b1;
          end else begin
            e1 = 1'b1; e1k = clx_pkg::K_INT; e1t = 1'b1;
          end
        end
        clx_pkg::M_SYM: begin
          if (clx_pkg::is_alpha(c) || clx_pkg::is_digit(c) || c == "." || c == "_") begin
            capp = 1'b1; cch = clx_pkg::lower(c); done = 1'b1;
          end else begin
            e1 = 1'b1; e1k = hk; e1t = !hit;
          end
        end
        clx_pkg::M_STR: begin
          done = 1'b1;
          if (c == clx_pkg::CH_NUL) begin
            f3 = 1'b1;
          end else if (c == "\"") begin
            e1 = 1'b1; e1k = clx_pkg::K_STR; e1t = 1'b1;
          end else begin
            capp = 1'b1; cch = c;
          end
        end
        clx_pkg::M_AMP: begin
          e1 = 1'b1; e1k = pend_q;
          if (c == "&") begin
            e1k = clx_pkg::K_AND; done = 1'b1;
          end
        end
        clx_pkg::M_EQ: begin
          e1 = 1'b1; e1k = pend_q;
          if (c == "=") begin
            e1k = clx_pkg::K_EQ; done = 1'b1;
          end
        end
        clx_pkg::M_BANG: begin
          e1 = 1'b1; e1k = pend_q;
          if (c == "=") begin
            e1k = clx_pkg::K_NE; done = 1'b1;
          end
        end
        clx_pkg::M_LT: begin
          e1 = 1'b1; e1k = pend_q;
          if (c == "<") begin
            e1k = clx_pkg::K_SHL; done = 1'b1;
          end else if (c == "=") begin
            e1k = clx_pkg::K_LE; done = 1'b1;
          end
        end
        clx_pkg::M_GT: begin
          e1 = 1'b1; e1k = pend_q;
          if (c == ">") begin
            e1k = clx_pkg::K_SHR; done = 1'b1;
          end else if (c == "=") begin
            e1k = clx_pkg::K_GE; done = 1'b1;
          end
        end
        default: ;
      endcase

      if (e1) begin
        txt = e1t && (len_q != '0);
        cv[n] = clx_pkg::mk_cmd(e1k, sl_q, sc_q, 8'h00, 1'b0, txt, len_q, bank_q,
                                clx_pkg::E_NONE);
        n = n + 2'd1;
        prev_d = (e1k == clx_pkg::K_SEMI);
        mode_d = clx_pkg::M_IDLE;
        len_d  = '0;
        if (txt) begin
          bank_d = ~bank_q;
        end
      end

      if (capp) begin
        if (int'(len_q) >= clx_pkg::TEXT_MAX) begin
          cv[n] = clx_pkg::mk_cmd(clx_pkg::K_END, ln, cl, 8'h00, 1'b0, 1'b0, '0, 1'b0,
                                  clx_pkg::E_LONG);
          n = n + 2'd1;
          halt_d = 1'b1; mode_d = clx_pkg::M_IDLE; len_d = '0;
        end else begin
          wr_o.en = 1'b1; wr_o.addr = {bank_q, len_q}; wr_o.data = cch;
          len_d  = len_q + clx_pkg::len_t'(1);
          cand_d = clx_pkg::cand_upd(cand_q, len_q, cch);
        end
      end

      if (f3) begin
        cv[n] = clx_pkg::mk_cmd(clx_pkg::K_END, ln, cl, 8'h00, 1'b0, 1'b0, '0, 1'b0,
                                clx_pkg::E_UNTERM);
        n = n + 2'd1;
        halt_d = 1'b1; mode_d = clx_pkg::M_IDLE; len_d = '0;
      end

      if (!done) begin
        sk = clx_pkg::single_kind(c);
        if (c == clx_pkg::CH_SP || c == clx_pkg::CH_TAB || c == clx_pkg::CH_CR ||
            c == clx_pkg::CH_LF) begin
          mode_d = clx_pkg::M_IDLE;
        end else if (c == clx_pkg::CH_NUL) begin
          sl_d = ln; sc_d = cl;
          if (!prev_d) begin
            cv[n] = clx_pkg::mk_cmd(clx_pkg::K_SEMI, ln, cl, 8'h00, 1'b0, 1'b0, '0, 1'b0,
                                    clx_pkg::E_NONE);
            n = n + 2'd1;
          end
          cv[n] = clx_pkg::mk_cmd(clx_pkg::K_END, ln, cl, 8'h00, 1'b0, 1'b0, '0, 1'b0,
                                  clx_pkg::E_NONE);
          n = n + 2'd1;
          halt_d = 1'b1;
        end else if (clx_pkg::is_digit(c) || clx_pkg::is_alpha(c) || c == "_") begin
          mode_d = clx_pkg::is_digit(c) ? clx_pkg::M_INT : clx_pkg::M_SYM;
          pend_d = clx_pkg::is_digit(c) ? clx_pkg::K_INT : clx_pkg::K_SYM;
          cch    = clx_pkg::is_digit(c) ? c : clx_pkg::lower(c);
          sl_d = ln; sc_d = cl;
          wr_o.en = 1'b1; wr_o.addr = {bank_d, clx_pkg::len_t'(0)}; wr_o.data = cch;
          len_d  = clx_pkg::len_t'(1);
          cand_d = clx_pkg::cand_upd('1, '0, cch);
        end else if (c == "\"") begin
          mode_d = clx_pkg::M_STR; pend_d = clx_pkg::K_STR;
          sl_d = ln; sc_d = cl; len_d = '0;
        end else if (sk != clx_pkg::K_END) begin
          sl_d = ln; sc_d = cl; pend_d = sk; mode_d = clx_pkg::M_IDLE;
          cv[n] = clx_pkg::mk_cmd(sk, ln, cl, 8'h00, 1'b0, 1'b0, '0, 1'b0,
                                  clx_pkg::E_NONE);
          n = n + 2'd1;
          prev_d = (sk == clx_pkg::K_SEMI);
        end else if (c == "&" || c == "=" || c == "!" || c == "<" || c == ">") begin
          sl_d = ln; sc_d = cl; len_d = '0;
          if (c == "&") begin
            mode_d = clx_pkg::M_AMP; pend_d = clx_pkg::K_AMP;
          end else if (c == "=") begin
            mode_d = clx_pkg::M_EQ; pend_d = clx_pkg::K_ASG;
          end else if (c == "!") begin
            mode_d = clx_pkg::M_BANG; pend_d = clx_pkg::K_NOT;
          end else if (c == "<") begin
            mode_d = clx_pkg::M_LT; pend_d = clx_pkg::K_LT;
          end else begin
            mode_d = clx_pkg::M_GT; pend_d = clx_pkg::K_GT;
          end
        end else begin
          cv[n] = clx_pkg::mk_cmd(clx_pkg::K_END, ln, cl, c, 1'b1, 1'b0, '0, 1'b0,
                                  clx_pkg::E_UNKNOWN);
          n = n + 2'd1;
          halt_d = 1'b1; mode_d = clx_pkg::M_IDLE; len_d = '0;
        end
      end

      if (n != 2'd0) begin
        cv[n - 2'd1].last = 1'b1;
      end
    end
    push_n_o = n;
    cmds_o   = cv;
  end

endmodule

[sv/clx_queue.sv]
module clx_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [1:0]              push_n_i,
  input  clx_pkg::cmd_t [2:0]     cmds_i,
  input  logic                    pop_i,
  output clx_pkg::cmd_t           head_o,
  output logic                    empty_o
);

  clx_pkg::cmd_t                mem_q [clx_pkg::Q_DEPTH];
  logic [clx_pkg::Q_AW-1:0]     rd_q, rd_d;
  logic [clx_pkg::Q_AW:0]       cnt_q, cnt_d;
  logic [clx_pkg::Q_AW-1:0]     wp;

  assign wp      = rd_q + cnt_q[clx_pkg::Q_AW-1:0];
  assign head_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);

  always_comb begin
    rd_d  = pop_i ? rd_q + clx_pkg::Q_AW'(1) : rd_q;
    cnt_d = cnt_q + (clx_pkg::Q_AW + 1)'(push_n_i) - (clx_pkg::Q_AW + 1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      if (j < int'(push_n_i)) begin
        mem_q[wp + clx_pkg::Q_AW'(j)] <= cmds_i[j];
      end
    end
  end

endmodule

[sv/clx_back.sv]
module clx_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  clx_pkg::wr_t    wr_i,
  input  clx_pkg::cmd_t   head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [5:0]      kind_o,
  output logic [15:0]     line_o,
  output logic [15:0]     column_o,
  output logic [7:0]      text_byte_o,
  output logic            has_text_o,
  output logic            token_end_o,
  output logic            last_o,
  output logic [1:0]      error_o
);

  logic [7:0]        store_q [2**(clx_pkg::LEN_W+1)];
  logic [7:0]        rd_q;
  clx_pkg::bk_e      st_q, st_d;
  clx_pkg::len_t     idx_q, idx_d;
  logic              ov_q, ov_d, load, fin;
  logic              free;

  logic [5:0]        kind_d;
  clx_pkg::pos_t     line_d, col_d;
  logic [7:0]        tb_d;
  logic              has_d, te_d, last_d;
  logic [1:0]        err_d;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      store_q[wr_i.addr] <= wr_i.data;
    end
    rd_q <= store_q[{head_i.bank, idx_d}];
  end

  always_comb begin
    free  = !ov_q || out_ready_i;
    st_d  = st_q;
    idx_d = idx_q;
    pop_o = 1'b0;
    load  = 1'b0;
    fin   = (idx_q == head_i.len - clx_pkg::len_t'(1));
    kind_d = head_i.kind; line_d = head_i.line; col_d = head_i.column;
    tb_d = head_i.tbyte; has_d = head_i.has; te_d = 1'b1; last_d = head_i.last;
    err_d = head_i.err;
    unique case (st_q)
      clx_pkg::BK_IDLE: begin
        idx_d = '0;
        if (!empty_i) begin
          if (head_i.text) begin
            st_d = clx_pkg::BK_TEXT;
          end else if (free) begin
            load  = 1'b1;
            pop_o = 1'b1;
          end
        end
      end
      clx_pkg::BK_TEXT: begin
        tb_d   = rd_q;
        has_d  = 1'b1;
        te_d   = fin;
        last_d = head_i.last && fin;
        if (free) begin
          load = 1'b1;
          if (fin) begin
            pop_o = 1'b1;
            st_d  = clx_pkg::BK_IDLE;
            idx_d = '0;
          end else begin
            idx_d = idx_q + clx_pkg::len_t'(1);
          end
        end
      end
      default: st_d = clx_pkg::BK_IDLE;
    endcase
    ov_d = load ? 1'b1 : (out_ready_i ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= clx_pkg::BK_IDLE;
      idx_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      idx_q <= idx_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_o      <= kind_d;
      line_o      <= line_d;
      column_o    <= col_d;
      text_byte_o <= tb_d;
      has_text_o  <= has_d;
      token_end_o <= te_d;
      last_o      <= last_d;
      error_o     <= err_d;
    end
  end

  assign out_valid_o = ov_q;

endmodule

[sv/c_subset_lexer_top.sv]
// An accepted beat's first result passes the command queue and then the output register; a
// token text run also passes the BK_TEXT state with its registered text read, and the run then
// moves one beat per cycle while out_ready_i is high. Input takes one beat per cycle while
// beats cause no result; after a beat that causes results the next is taken once the command
// queue is empty. After an error or the end token input is taken and dropped.
// Reset is asynchronous and active low: line 1, column 0, scanner idle; text memory is not cleared.
module c_subset_lexer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_req_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  kind_o,
  output logic [15:0] line_o,
  output logic [15:0] column_o,
  output logic [7:0]  text_byte_o,
  output logic        has_text_o,
  output logic        token_end_o,
  output logic        last_o,
  output logic [1:0]  error_o
);

  logic                 halted, empty, pop;
  logic [1:0]           push_n;
  clx_pkg::cmd_t [2:0]  cmds;
  clx_pkg::cmd_t        head;
  clx_pkg::wr_t         wr;

  assign in_ready_o = halted || empty;

  clx_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (in_valid_i && in_ready_o),
    .byte_i   (byte_req_i),
    .eof_i    (end_of_file_i),
    .halted_o (halted),
    .push_n_o (push_n),
    .cmds_o   (cmds),
    .wr_o     (wr)
  );

  clx_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .cmds_i   (cmds),
    .pop_i    (pop),
    .head_o   (head),
    .empty_o  (empty)
  );

  clx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .line_o      (line_o),
    .column_o    (column_o),
    .text_byte_o (text_byte_o),
    .has_text_o  (has_text_o),
    .token_end_o (token_end_o),
    .last_o      (last_o),
    .error_o     (error_o)
  );

endmodule

[tb/c_subset_lexer_top_test.sv]
`timescale 1ns / 100ps

module c_subset_lexer_top_test;
  import clx_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 470;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef struct {
    logic [5:0] kind;
    pos_t       line;
    pos_t       column;
    logic [7:0] tbyte;
    logic       has;
    logic       tend;
    logic       last;
    logic [1:0] err;
  } lexeme_t;

  typedef struct {
    logic [7:0] b;
    logic       eof;
    logic       rush;
    logic       typed;
    logic [5:0] tkind;
  } stim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  byte_req_i = 8'h20;
  logic        end_of_file_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [5:0]  kind_o;
  logic [15:0] line_o;
  logic [15:0] column_o;
  logic [7:0]  text_byte_o;
  logic        has_text_o;
  logic        token_end_o;
  logic        last_o;
  logic [1:0]  error_o;

  c_subset_lexer_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .byte_req_i    (byte_req_i),
    .end_of_file_i (end_of_file_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .line_o        (line_o),
    .column_o      (column_o),
    .text_byte_o   (text_byte_o),
    .has_text_o    (has_text_o),
    .token_end_o   (token_end_o),
    .last_o        (last_o),
    .error_o       (error_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Scanner state as the predictor sees it.
  mode_e      scan_st = M_IDLE;
  pos_t       line_cnt = 1;
  pos_t       col_cnt = 0;
  logic [5:0] pend_kind = K_END;
  logic [7:0] txt [TEXT_LIMIT];
  int         txt_len = 0;
  pos_t       tok_line = 1;
  pos_t       tok_col = 0;
  bit         prev_semi = 1'b0;
  bit         stopped = 1'b0;

  lexeme_t tokens_due[$];
  stim_t   src[$];
  int      mismatches = 0;
  int      results_seen = 0;
  int      idle_cycles = 0;

  string      kw_words [16] = '{"if", "else", "while", "do", "for", "continue", "int", "short",
                                "char", "signed", "unsigned", "void", "switch", "case", "break",
                                "goto"};
  logic [5:0] kw_kinds [16] = '{6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd11, 6'd12, 6'd13,
                                6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19};
  string      op_words [25] = '{",", "(", ")", "[", "]", "{", "}", "+", "-", "/", "*", "%", ":",
                                ";", "&", "&&", "=", "==", "!", "!=", "<", "<<", "<=", ">", ">>"};

  stim_t directed [25] = '{
    '{";", 0, 0, 1, K_SEMI}, '{"I", 0, 0, 0, K_END}, '{"F", 0, 0, 0, K_END},
    '{CH_SP, 0, 0, 0, K_END}, '{"Z", 0, 0, 0, K_END}, '{".", 0, 0, 0, K_END},
    '{"_", 0, 0, 0, K_END}, '{"9", 0, 0, 0, K_END}, '{CH_TAB, 0, 0, 1, K_SYM},
    '{"0", 0, 0, 0, K_END}, '{"(", 0, 0, 0, K_END}, '{CH_QUOTE, 0, 0, 0, K_END},
    '{CH_QUOTE, 0, 0, 1, K_STR}, '{CH_QUOTE, 0, 0, 0, K_END}, '{8'hFF, 0, 0, 0, K_END},
    '{8'h80, 0, 0, 0, K_END}, '{CH_QUOTE, 0, 0, 1, K_STR}, '{"<", 0, 0, 0, K_END},
    '{"<", 0, 0, 1, K_SHL}, '{">", 0, 0, 0, K_END}, '{"=", 0, 0, 1, K_GE},
    '{"&", 0, 0, 0, K_END}, '{"x", 0, 0, 1, K_AMP}, '{CH_CR, 0, 0, 1, K_SYM},
    '{CH_LF, 0, 0, 0, K_END}
  };

  task automatic report(string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic bit dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alp(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [7:0] fold(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic pos_t bump(pos_t v, int d);
    return (int'(v) + d > 65535) ? 16'hFFFF : pos_t'(int'(v) + d);
  endfunction

  function automatic void push_token(logic [5:0] k, pos_t ln, pos_t col, logic [7:0] b,
                                     logic has, logic te, logic [1:0] er);
    lexeme_t x;
    x.kind = k; x.line = ln; x.column = col; x.tbyte = b;
    x.has = has; x.tend = te; x.last = 1'b0; x.err = er;
    tokens_due.push_back(x);
  endfunction

  function automatic void close_token(logic [5:0] k, bit with_text);
    if (with_text && txt_len > 0) begin
      for (int i = 0; i < txt_len; i++) begin
        push_token(k, tok_line, tok_col, txt[i], 1'b1, i + 1 == txt_len, E_NONE);
      end
    end else begin
      push_token(k, tok_line, tok_col, 8'h00, 1'b0, 1'b1, E_NONE);
    end
    prev_semi = (k == K_SEMI);
    scan_st = M_IDLE;
    txt_len = 0;
  endfunction

  function automatic void halt_with(logic [1:0] er, logic [7:0] b, bit show);
    push_token(K_END, line_cnt, col_cnt, show ? b : 8'h00, show, 1'b1, er);
    stopped = 1'b1;
    scan_st = M_IDLE;
    txt_len = 0;
  endfunction

  function automatic void add_char(logic [7:0] c);
    if (txt_len >= TEXT_MAX) begin
      halt_with(E_LONG, 8'h00, 1'b0);
    end else begin
      txt[txt_len] = c;
      txt_len++;
    end
  endfunction

  function automatic void close_symbol();
    bit hit;
    for (int k = 0; k < 16; k++) begin
      hit = kw_words[k].len() == txt_len;
      for (int j = 0; hit && j < txt_len; j++) begin
        if (kw_words[k][j] != txt[j]) hit = 1'b0;
      end
      if (hit) begin
        close_token(kw_kinds[k], 1'b0);
        return;
      end
    end
    close_token(K_SYM, 1'b1);
  endfunction

  function automatic void begin_token(mode_e m, logic [5:0] k);
    scan_st = m;
    pend_kind = k;
    tok_line = line_cnt;
    tok_col = col_cnt;
    txt_len = 0;
  endfunction

  function automatic logic [5:0] single_of(logic [7:0] c);
    case (c)
      ",": return 6'd20;
      "(": return 6'd21;
      ")": return 6'd22;
      "[": return 6'd23;
      "]": return 6'd24;
      "{": return 6'd25;
      "}": return 6'd26;
      "+": return 6'd27;
      "-": return 6'd28;
      "/": return 6'd29;
      "*": return 6'd30;
      "%": return 6'd43;
      ":": return 6'd44;
      ";": return K_SEMI;
      default: return K_END;
    endcase
  endfunction

  function automatic void scan_fresh(logic [7:0] c);
    logic [5:0] sk;
    sk = single_of(c);
    if (c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF) return;
    if (c == CH_NUL) begin
      tok_line = line_cnt;
      tok_col = col_cnt;
      if (!prev_semi) close_token(K_SEMI, 1'b0);
      close_token(K_END, 1'b0);
      stopped = 1'b1;
    end else if (dig(c)) begin
      begin_token(M_INT, K_INT);
      add_char(c);
    end else if (alp(c) || c == "_") begin
      begin_token(M_SYM, K_SYM);
      add_char(fold(c));
    end else if (c == CH_QUOTE) begin
      begin_token(M_STR, K_STR);
    end else if (sk != K_END) begin
      begin_token(M_IDLE, sk);
      close_token(sk, 1'b0);
    end else begin
      case (c)
        "&": begin_token(M_AMP, K_AMP);
        "=": begin_token(M_EQ, K_ASG);
        "!": begin_token(M_BANG, K_NOT);
        "<": begin_token(M_LT, K_LT);
        ">": begin_token(M_GT, K_GT);
        default: halt_with(E_UNKNOWN, c, 1'b1);
      endcase
    end
  endfunction

  // Returns 1 when the byte was used by the token in progress.
  function automatic bit continue_token(logic [7:0] c);
    case (scan_st)
      M_INT: begin
        if (dig(c)) begin
          add_char(c);
          return 1'b1;
        end
        close_token(K_INT, 1'b1);
        return 1'b0;
      end
      M_SYM: begin
        if (alp(c) || dig(c) || c == "." || c == "_") begin
          add_char(fold(c));
          return 1'b1;
        end
        close_symbol();
        return 1'b0;
      end
      M_STR: begin
        if (c == CH_NUL) halt_with(E_UNTERM, 8'h00, 1'b0);
        else if (c == CH_QUOTE) close_token(K_STR, 1'b1);
        else add_char(c);
        return 1'b1;
      end
      M_AMP: if (c == "&") begin
        close_token(K_AND, 1'b0);
        return 1'b1;
      end
      M_EQ: if (c == "=") begin
        close_token(K_EQ, 1'b0);
        return 1'b1;
      end
      M_BANG: if (c == "=") begin
        close_token(K_NE, 1'b0);
        return 1'b1;
      end
      M_LT: if (c == "<" || c == "=") begin
        close_token(c == "<" ? K_SHL : K_LE, 1'b0);
        return 1'b1;
      end
      M_GT: if (c == ">" || c == "=") begin
        close_token(c == ">" ? K_SHR : K_GE, 1'b0);
        return 1'b1;
      end
      default: begin
        scan_st = M_IDLE;
        return 1'b0;
      end
    endcase
    close_token(pend_kind, 1'b0);
    return 1'b0;
  endfunction

  function automatic void predict_tokens(logic [7:0] b, logic eof);
    logic [7:0] c;
    int n0;
    if (stopped) return;
    c = eof ? CH_NUL : b;
    n0 = tokens_due.size();
    col_cnt = bump(col_cnt, 1);
    if (c == CH_NUL || c == CH_LF) begin
      line_cnt = bump(line_cnt, 1);
      col_cnt = 0;
    end else if (c == CH_TAB) begin
      col_cnt = bump(col_cnt, 3);
    end else if (c == CH_CR) begin
      col_cnt = 0;
    end
    if (!continue_token(c) && !stopped) scan_fresh(c);
    if (tokens_due.size() > n0) tokens_due[$].last = 1'b1;
  endfunction

  function automatic void add_byte(logic [7:0] b, logic eof = 1'b0, logic rush = 1'b0);
    stim_t s;
    s.b = b; s.eof = eof; s.rush = rush; s.typed = 1'b0; s.tkind = K_END;
    src.push_back(s);
  endfunction

  function automatic void add_blank();
    logic [7:0] ws [4] = '{CH_SP, CH_TAB, CH_CR, CH_LF};
    add_byte(ws[$urandom_range(0, 3)]);
  endfunction

  function automatic int pick_len();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(20, TEXT_MAX) : $urandom_range(1, 8);
  endfunction

  // Well-formed tokens only: no byte here can halt the scanner.
  function automatic void add_random_token();
    string w;
    logic [7:0] c;
    int n;
    case ($urandom_range(0, 9))
      0, 1: begin
        n = pick_len();
        for (int i = 0; i < n; i++) add_byte(8'("0") + 8'($urandom_range(0, 9)));
        add_blank();
      end
      2, 3: begin
        if ($urandom_range(0, 2) == 0) begin
          w = kw_words[$urandom_range(0, 15)];
          for (int i = 0; i < w.len(); i++) begin
            c = w[i];
            add_byte($urandom_range(0, 1) ? c - 8'd32 : c);
          end
        end else begin
          n = pick_len();
          for (int i = 0; i < n; i++) begin
            case ((i == 0) ? $urandom_range(0, 2) : $urandom_range(0, 4))
              0: c = 8'("a") + 8'($urandom_range(0, 25));
              1: c = 8'("A") + 8'($urandom_range(0, 25));
              2: c = "_";
              3: c = 8'("0") + 8'($urandom_range(0, 9));
              default: c = ".";
            endcase
            add_byte(c);
          end
        end
        add_blank();
      end
      4: begin
        add_byte(CH_QUOTE);
        n = ($urandom_range(0, 3) == 0) ? 0 : pick_len();
        for (int i = 0; i < n; i++) begin
          c = 8'($urandom_range(1, 255));
          add_byte(c == CH_QUOTE ? c + 8'd1 : c);
        end
        add_byte(CH_QUOTE);
      end
      5: add_blank();
      default: begin
        w = op_words[$urandom_range(0, 24)];
        for (int i = 0; i < w.len(); i++) add_byte(w[i]);
      end
    endcase
  endfunction

  // A run of beats that ends in the one halting beat, then beats that must be dropped.
  function automatic void add_ending();
    case ($urandom_range(0, 4))
      0: add_byte(8'($urandom_range(0, 255)), 1'b1);
      1: add_byte(CH_NUL);
      2: add_byte($urandom_range(0, 1) ? 8'($urandom_range(128, 255)) : ".");
      3: for (int i = 0; i <= TEXT_MAX; i++) add_byte("7");
      default: begin
        add_byte(CH_QUOTE);
        add_byte("a");
        add_byte(8'hC3);
        add_byte(8'h00, 1'b1);
      end
    endcase
    for (int i = 0; i < 5; i++) add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    int n0;
    bit steady;
    int gap;
    foreach (directed[i]) src.push_back(directed[i]);
    while (src.size() < 25 + RANDOM_ITEMS / 2) add_random_token();
    n0 = src.size();
    while (src.size() < n0 + RANDOM_ITEMS / 2) add_random_token();
    add_ending();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    steady = 1'b0;
    foreach (src[i]) begin
      if (i % 60 == 0) steady = $urandom_range(0, 3) == 0;
      gap = (steady || src[i].rush) ? 0 : pick_gap();
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      byte_req_i <= src[i].b;
      end_of_file_i <= src[i].eof;
      do @(posedge clk_i); while (!in_ready_o);
      n0 = tokens_due.size();
      predict_tokens(src[i].b, src[i].eof);
      if (src[i].typed && tokens_due.size() > n0) begin
        if (tokens_due[$].kind != src[i].tkind) begin
          report($sformatf("table row %0d predicts kind %0d", i, tokens_due[$].kind));
        end
        tokens_due[$].kind = src[i].tkind;
      end
    end
    in_valid_i <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    lexeme_t x;
    int hold;
    bit held;
    hold = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (tokens_due.size() == 0) begin
          report($sformatf("unexpected beat kind %0d err %0d", kind_o, error_o));
        end else begin
          x = tokens_due.pop_front();
          if ({kind_o, line_o, column_o, text_byte_o, has_text_o, token_end_o, last_o,
               error_o} !== {x.kind, x.line, x.column, x.tbyte, x.has, x.tend, x.last,
               x.err}) begin
            report($sformatf({"got kind %0d line %0d col %0d byte %h has %b end %b last %b ",
                              "err %0d, want %0d %0d %0d %h %b %b %b %0d"},
                             kind_o, line_o, column_o, text_byte_o, has_text_o, token_end_o,
                             last_o, error_o, x.kind, x.line, x.column, x.tbyte, x.has,
                             x.tend, x.last, x.err));
          end
        end
      end
      if (!held && results_seen >= 150) begin
        held = 1'b1;
        hold = 300;
      end else if (hold == 0 && (results_seen / 200) % 2 == 0) begin
        hold = pick_gap();
      end
      if (hold > 0) hold--;
      out_ready_i <= (hold == 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
